// File: rtl/hcb_pkg.sv
// Shared types, constants and mod-26 arithmetic for the Hill cipher block.
package hcb_pkg;

	localparam int HCB_MAX_BLOCK = 4;
	localparam int KEY_DIM       = 4;
	localparam int LETTER_W      = 5;
	localparam int ROW_W         = 20;
	localparam int CFG_W         = 20;
	localparam int NUM_PERMS     = 24;
	localparam int NUM_DETS      = 17;
	localparam logic [4:0] MODULUS = 5'd26;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [KEY_DIM-1:0][ROW_W-1:0] key_mat_t;

	typedef enum logic [2:0] {
		REG_MODE  = 3'd0,
		REG_BLEN  = 3'd1,
		REG_KEY_A = 3'd2,
		REG_KEY_B = 3'd3,
		REG_KEY_C = 3'd4,
		REG_KEY_D = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DERIVE,
		ST_MAC,
		ST_EMIT
	} hcb_state_t;

	typedef enum logic [1:0] {
		IS_IDLE,
		IS_DET,
		IS_SCALE
	} inv_state_t;

	typedef struct packed {
		logic ready;
		logic bad;
		logic done;
	} inv_stat_t;

	// permutations of 0..3, column of row t at bits [2t+1:2t]
	localparam logic [7:0] PERM_COLS [NUM_PERMS] = '{
		8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
		8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
		8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
		8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
	};
	localparam logic [NUM_PERMS-1:0] PERM_ODD = 24'h666666;

	function automatic letter_t red26(input letter_t x);
		return (x >= MODULUS) ? x - MODULUS : x;
	endfunction

	// (a*b + c) mod 26, a, b, c below 26
	function automatic letter_t mulmod26(input letter_t a, input letter_t b, input letter_t c);
		logic [10:0] x;
		logic [20:0] p;
		logic [4:0]  q;
		logic [10:0] r;
		x = {6'd0, a} * {6'd0, b} + {6'd0, c};
		p = {10'd0, x} * 21'd2521;
		q = p[20:16];
		r = x - {6'd0, q} * 11'd26;
		return r[4:0];
	endfunction

	function automatic letter_t addsub26(input letter_t acc, input letter_t v, input logic neg);
		logic [5:0] s;
		s = {1'b0, acc} + (neg ? (6'd26 - {1'b0, v}) : {1'b0, v});
		return (s >= 6'd26) ? 5'(s - 6'd26) : s[4:0];
	endfunction

	function automatic letter_t mod_inv26(input letter_t d);
		letter_t r;
		case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic letter_t key_entry(input key_mat_t k, input logic [1:0] r,
		input logic [1:0] c);
		return red26(k[r][5*c +: 5]);
	endfunction

endpackage

// File: rtl/hcb_cell.sv
// One letter cell of the block ring: loads a letter or takes its neighbor's.
module hcb_cell import hcb_pkg::*; (
	input  logic    clk,
	input  logic    wr_en,
	input  letter_t wr_data,
	input  logic    shift_en,
	input  letter_t nbr,
	output letter_t letter_q
);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			letter_q <= wr_data;
		end else if (shift_en) begin
			letter_q <= nbr;
		end
	end

endmodule

// File: rtl/hcb_inv.sv
// Inverse key unit: determinant and cofactors by permutation sums, then scaling.
module hcb_inv import hcb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         clear,
	input  logic [2:0]   n,
	input  key_mat_t     key,
	input  logic [3:0]   rd_addr,
	output letter_t      rd_data,
	output inv_stat_t    stat
);

	inv_state_t state_q, state_d;
	logic [4:0] d_q;
	logic [4:0] p_q;
	logic [1:0] t_q;
	logic [3:0] e_q;
	letter_t    term_q, acc_q, det_q;
	logic       ready_q, bad_q;
	letter_t    inv_q [16];

	logic [1:0] col, ci, cj;
	logic [3:0] cof;
	logic [3:0] rd_ptr;
	letter_t    ent, prod, acc_new, inv, rd_val;
	logic       in_blk, last_p, last_d, done;

	assign cof    = 4'(d_q - 5'd1);
	assign ci     = cof[3:2];
	assign cj     = cof[1:0];
	assign col    = PERM_COLS[p_q][2*t_q +: 2];
	assign in_blk = ({1'b0, t_q} < n) && ({1'b0, col} < n);
	assign last_p = (p_q == 5'(NUM_PERMS - 1));
	assign last_d = (d_q == 5'(NUM_DETS - 1));
	assign inv    = mod_inv26(det_q);

	always_comb begin
		if (d_q != 5'd0 && t_q == ci) begin
			ent = {4'd0, col == cj};
		end else if (in_blk) begin
			ent = key_entry(key, t_q, col);
		end else begin
			ent = {4'd0, t_q == col};
		end
	end

	assign prod    = mulmod26((t_q == 2'd0) ? 5'd1 : term_q, ent, 5'd0);
	assign acc_new = addsub26((p_q == 5'd0) ? 5'd0 : acc_q, prod, PERM_ODD[p_q]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			IS_IDLE:  if (start) state_d = IS_DET;
			IS_DET:   if (t_q == 2'd3 && last_p && last_d) state_d = IS_SCALE;
			IS_SCALE: if (e_q == 4'd15) state_d = IS_IDLE;
			default:  state_d = IS_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == IS_SCALE) && (e_q == 4'd15);
		rd_ptr = (state_q == IS_SCALE) ? e_q : rd_addr;
	end

	assign rd_val  = inv_q[rd_ptr];
	assign rd_data = rd_val;
	assign stat    = '{ready: ready_q, bad: bad_q, done: done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IS_IDLE;
			d_q     <= '0;
			p_q     <= '0;
			t_q     <= '0;
			e_q     <= '0;
			ready_q <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear) ready_q <= 1'b0;
			case (state_q)
				IS_IDLE: begin
					d_q <= '0;
					p_q <= '0;
					t_q <= '0;
					e_q <= '0;
				end
				IS_DET: begin
					t_q <= t_q + 2'd1;
					if (t_q == 2'd3) begin
						if (last_p) begin
							p_q <= '0;
							d_q <= last_d ? 5'd0 : d_q + 5'd1;
						end else begin
							p_q <= p_q + 5'd1;
						end
					end
				end
				IS_SCALE: begin
					e_q   <= e_q + 4'd1;
					bad_q <= (inv == 5'd0);
					if (done) ready_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IS_DET) begin
			if (t_q != 2'd3) begin
				term_q <= prod;
			end else begin
				acc_q <= acc_new;
				if (last_p) begin
					if (d_q == 5'd0) begin
						det_q <= acc_new;
					end else begin
						inv_q[{cj, ci}] <= acc_new;
					end
				end
			end
		end else if (state_q == IS_SCALE) begin
			inv_q[e_q] <= mulmod26(inv, rd_val, 5'd0);
		end
	end

endmodule

// File: rtl/hill_cipher_block_mod26.sv
// Hill cipher mod 26: letters go into a ring of cells; a block of n letters
// (n = block_len clamped to 1..MAX_BLOCK) is multiplied by the key, or by its
// inverse in decrypt mode, through one mod-26 multiply-accumulate at cell 0
// while the ring rotates. A letter that does not close a block is stored. A
// closing letter starts the work, during which no letter is taken: per result
// row, a multiply-accumulate over the n letters, then a hand-off to the output
// register, held while it is full. The first decrypt block after any register
// write first derives the inverse key: 17 determinants of 24 four-factor terms,
// one factor a cycle, then the 16 entries are scaled. Results leave through an
// output register, so the next letters are taken while a result waits.
module hill_cipher_block_mod26 import hcb_pkg::*; #(
	parameter int MAX_BLOCK = HCB_MAX_BLOCK
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  letter_t          letter_in,
	output logic             out_valid,
	input  logic             out_ready,
	output letter_t          letter_out,
	output logic             last_of_block,
	output logic             key_error
);

	hcb_state_t state_q, state_d;
	logic       mode_q;
	logic [2:0] blen_q;
	key_mat_t   key_q;
	logic [2:0] fill_q;
	logic [1:0] row_q, col_q;
	letter_t    acc_q;

	logic [2:0] n_eff, fill_next;
	logic       accept, blk_done, need_inv, last_col, last_row, out_free, err;
	logic       shift_en, inv_start, out_load;
	letter_t    head, coef, mac_out, inv_rd;
	inv_stat_t  inv_stat;
	letter_t    cell_letter [MAX_BLOCK];

	assign n_eff = (blen_q == 3'd0) ? 3'd1 :
		(blen_q > 3'(MAX_BLOCK)) ? 3'(MAX_BLOCK) : blen_q;

	assign accept    = in_valid && in_ready;
	assign fill_next = fill_q + 3'd1;
	assign blk_done  = (fill_next >= n_eff);
	assign need_inv  = mode_q && !inv_stat.ready;
	assign last_col  = ({1'b0, col_q} == n_eff - 3'd1);
	assign last_row  = ({1'b0, row_q} == n_eff - 3'd1);
	assign out_free  = !out_valid || out_ready;
	assign err       = mode_q && inv_stat.bad;

	assign head    = red26(cell_letter[0]);
	assign coef    = mode_q ? inv_rd : key_entry(key_q, row_q, col_q);
	assign mac_out = mulmod26(coef, head, (col_q == 2'd0) ? 5'd0 : acc_q);

	for (genvar k = 0; k < MAX_BLOCK; k++) begin : g_cell
		letter_t nbr;
		if (k == MAX_BLOCK - 1) begin : g_wrap
			assign nbr = cell_letter[0];
		end else begin : g_mid
			assign nbr = (n_eff == 3'(k + 1)) ? cell_letter[0] : cell_letter[k+1];
		end
		hcb_cell u_cell (
			.clk      (clk),
			.wr_en    (accept && fill_q == 3'(k)),
			.wr_data  (letter_in),
			.shift_en (shift_en),
			.nbr      (nbr),
			.letter_q (cell_letter[k])
		);
	end

	hcb_inv u_inv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (inv_start),
		.clear   (cfg_we && cfg_index <= REG_KEY_D),
		.n       (n_eff),
		.key     (key_q),
		.rd_addr ({row_q, col_q}),
		.rd_data (inv_rd),
		.stat    (inv_stat)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept && blk_done) state_d = need_inv ? ST_DERIVE : ST_MAC;
			ST_DERIVE: if (inv_stat.done) state_d = ST_MAC;
			ST_MAC:    if (last_col) state_d = ST_EMIT;
			ST_EMIT:   if (out_free) state_d = last_row ? ST_IDLE : ST_MAC;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		shift_en  = (state_q == ST_MAC);
		inv_start = (state_q == ST_IDLE) && accept && blk_done && need_inv;
		out_load  = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= 1'b0;
			blen_q    <= 3'd3;
			key_q     <= '0;
			fill_q    <= '0;
			row_q     <= '0;
			col_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: mode_q <= cfg_data[0];
					REG_BLEN: blen_q <= cfg_data[2:0];
					REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D:
						key_q[2'(cfg_index - 3'(REG_KEY_A))] <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				fill_q <= blk_done ? 3'd0 : fill_next;
				row_q  <= '0;
				col_q  <= '0;
			end
			if (state_q == ST_MAC) begin
				col_q <= last_col ? 2'd0 : col_q + 2'd1;
			end
			if (out_load) begin
				row_q <= row_q + 2'd1;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MAC) begin
			acc_q <= mac_out;
		end
		if (out_load) begin
			letter_out    <= err ? 5'd0 : acc_q;
			last_of_block <= last_row;
			key_error     <= err;
		end
	end

endmodule

// File: rtl/hcb_checker.sv
// Port checks for the Hill cipher block, bound to the top level.
module hcb_checker import hcb_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    out_valid,
	input logic    out_ready,
	input letter_t letter_out,
	input logic    last_of_block,
	input logic    key_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(letter_out)) else
		$error("output beat dropped or changed while stalled");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> letter_out < MODULUS) else
		$error("letter_out not reduced mod 26");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_error |-> letter_out == 5'd0) else
		$error("key error beat carries a nonzero letter");

	a_err_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_block ##1 out_valid |->
		key_error == $past(key_error)) else
		$error("key_error changed inside a block");

endmodule

bind hill_cipher_block_mod26 hcb_checker u_hcb_checker (.*);

// File: tb/hill_cipher_block_mod26_test.sv
// Testbench for hill_cipher_block_mod26: directed table, then random blocks checked against a predictor.
module hill_cipher_block_mod26_test;
	import hcb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 395;

	typedef struct {
		letter_t letter;
		logic    last;
		logic    err;
	} cipher_beat_t;

	typedef enum logic {ROW_CFG, ROW_LETTER} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		cfg_reg_t   idx;
		logic [19:0] data;
		logic       fixed;
		letter_t    fixed_letter;
		logic       fixed_err;
	} stim_row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_ready;
	letter_t letter_in;
	logic out_valid, out_ready;
	letter_t letter_out;
	logic last_of_block, key_error;

	hill_cipher_block_mod26 u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .letter_in(letter_in),
		.out_valid(out_valid), .out_ready(out_ready), .letter_out(letter_out),
		.last_of_block(last_of_block), .key_error(key_error)
	);

	// predictor state
	logic        mode_dec;
	logic [2:0]  blen;
	logic [19:0] key_rows [4];
	int          buf_l [4];
	int          fill;
	int          inv_key [4][4];
	logic        inv_ready, key_bad;

	cipher_beat_t pending_q [$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("hill_cipher_block_mod26 test failed");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int kent(input int r, input int c);
		return int'((key_rows[r] >> (5 * c)) & 20'd31);
	endfunction

	function automatic int mod_pos(input longint v);
		longint r;
		r = v % 26;
		if (r < 0) r += 26;
		return int'(r);
	endfunction

	// determinant mod 26 by permutation expansion
	function automatic int det_mod(input int m [4][4], input int n);
		longint acc, prod;
		int p [4];
		int code, total, t, u, inv;
		logic ok;
		acc = 0;
		total = n ** n;
		for (code = 0; code < total; code++) begin
			t = code;
			for (u = 0; u < n; u++) begin
				p[u] = t % n;
				t = t / n;
			end
			ok = 1'b1;
			inv = 0;
			for (t = 0; t < n; t++)
				for (u = t + 1; u < n; u++) begin
					if (p[t] == p[u]) ok = 1'b0;
					if (p[t] > p[u]) inv++;
				end
			if (ok) begin
				prod = 1;
				for (t = 0; t < n; t++) prod = prod * m[t][p[t]];
				acc = (inv % 2) ? acc - prod : acc + prod;
			end
		end
		return mod_pos(acc);
	endfunction

	function automatic void derive_inverse(input int n);
		int km [4][4];
		int sub [4][4];
		int adj [4][4];
		int d, dinv, x, i, j, r, c, rr, cc;
		for (i = 0; i < 4; i++)
			for (j = 0; j < 4; j++) begin
				km[i][j] = (i < n && j < n) ? kent(i, j) : 0;
				sub[i][j] = 0;
				adj[i][j] = 0;
			end
		d = det_mod(km, n);
		dinv = 0;
		for (x = 1; x < 26; x++)
			if (dinv == 0 && (d * x) % 26 == 1) dinv = x;
		key_bad = (dinv == 0);
		if (n == 1) adj[0][0] = 1;
		else begin
			for (i = 0; i < n; i++)
				for (j = 0; j < n; j++) begin
					rr = 0;
					for (r = 0; r < n; r++) begin
						if (r != i) begin
							cc = 0;
							for (c = 0; c < n; c++)
								if (c != j) begin
									sub[rr][cc] = km[r][c];
									cc++;
								end
							rr++;
						end
					end
					x = det_mod(sub, n - 1);
					adj[j][i] = ((i + j) % 2) ? mod_pos(-x) : x;
				end
		end
		for (i = 0; i < 4; i++)
			for (j = 0; j < 4; j++) inv_key[i][j] = (dinv * adj[i][j]) % 26;
		inv_ready = 1'b1;
	endfunction

	function automatic void model_write(input cfg_reg_t idx, input logic [19:0] v);
		case (idx)
			REG_MODE:  mode_dec = v[0];
			REG_BLEN:  blen = v[2:0];
			REG_KEY_A: key_rows[0] = v;
			REG_KEY_B: key_rows[1] = v;
			REG_KEY_C: key_rows[2] = v;
			REG_KEY_D: key_rows[3] = v;
			default: ;
		endcase
		inv_ready = 1'b0;
	endfunction

	// returns number of result letters queued
	function automatic int encipher_letter(input letter_t l, input logic fixed,
		input letter_t fl, input logic fe);
		int n, i, k, sum;
		logic err;
		cipher_beat_t b;
		n = (blen < 1) ? 1 : (blen > 4) ? 4 : int'(blen);
		buf_l[fill & 3] = int'(l);
		fill = (fill + 1) & 7;
		if (fill < n) return 0;
		fill = 0;
		err = 1'b0;
		if (mode_dec) begin
			if (!inv_ready) derive_inverse(n);
			err = key_bad;
		end
		for (i = 0; i < n; i++) begin
			sum = 0;
			if (!err)
				for (k = 0; k < n; k++)
					sum += (mode_dec ? inv_key[i][k] : kent(i, k)) * buf_l[k];
			b.letter = letter_t'(sum % 26);
			b.last = (i == n - 1);
			b.err = err;
			if (fixed) begin
				b.letter = fl;
				b.err = fe;
			end
			pending_q.insert(pending_q.size(), b);
		end
		return n;
	endfunction

	// entered and left at a falling edge
	task automatic send_letter(input letter_t l, input logic fixed = 1'b0,
		input letter_t fl = '0, input logic fe = 1'b0);
		int gap;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 3);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		letter_in <= l;
		do @(posedge clk); while (!(in_valid && in_ready));
		void'(encipher_letter(l, fixed, fl, fe));
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [19:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		model_write(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// receiver
	initial begin
		int window, pat;
		window = 0;
		pat = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (window == 0) begin
				window = $urandom_range(16, 80);
				pat = $urandom_range(0, 3);
			end
			window--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else case (pat)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		cipher_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) report("unexpected beat", letter_out, -1);
			else begin
				e = pending_q.pop_front();
				if (letter_out !== e.letter) report("letter_out", letter_out, e.letter);
				if (last_of_block !== e.last) report("last_of_block", last_of_block, e.last);
				if (key_error !== e.err) report("key_error", key_error, e.err);
			end
		end
	end

	stim_row_t dir_rows [$];

	function automatic void add_cfg(input cfg_reg_t idx, input logic [19:0] v);
		stim_row_t r;
		r = '{ROW_CFG, idx, v, 1'b0, '0, 1'b0};
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic void add_letter(input letter_t l, input logic fx = 1'b0,
		input letter_t fl = '0, input logic fe = 1'b0);
		stim_row_t r;
		r = '{ROW_LETTER, REG_MODE, '0, fx, fl, fe};
		r.data = 20'(l);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	initial begin
		int ph, cnt, i, sent;
		cfg_reg_t rr;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		in_valid = 1'b0;
		letter_in = '0;
		mode_dec = 1'b0;
		blen = 3'd3;
		for (i = 0; i < 4; i++) begin
			key_rows[i] = '0;
			buf_l[i] = 0;
		end
		fill = 0;
		inv_ready = 1'b0;
		key_bad = 1'b0;

		// zero key after reset, three-letter blocks
		add_letter(5'd25, 1'b1, 5'd0, 1'b0); add_letter(5'd0, 1'b1, 5'd0, 1'b0);
		add_letter(5'd25, 1'b1, 5'd0, 1'b0);
		// one-letter identity
		add_cfg(REG_BLEN, 20'd1); add_cfg(REG_KEY_A, 20'd1);
		add_letter(5'd25, 1'b1, 5'd25, 1'b0); add_letter(5'd0, 1'b1, 5'd0, 1'b0);
		// length zero behaves as one
		add_cfg(REG_BLEN, 20'd0);
		add_letter(5'd13, 1'b1, 5'd13, 1'b0);
		// length above max behaves as four, 4x4 identity
		add_cfg(REG_BLEN, 20'd7); add_cfg(REG_KEY_B, 20'h00020);
		add_cfg(REG_KEY_C, 20'h00400); add_cfg(REG_KEY_D, 20'h08000);
		add_letter(5'd0); add_letter(5'd25); add_letter(5'd1); add_letter(5'd24);
		// decrypt with identity
		add_cfg(REG_MODE, 20'd1);
		add_letter(5'd3); add_letter(5'd4); add_letter(5'd5); add_letter(5'd6);
		// singular key: zero row
		add_cfg(REG_KEY_B, 20'd0);
		add_letter(5'd1); add_letter(5'd2); add_letter(5'd3);
		add_letter(5'd4, 1'b1, 5'd0, 1'b1);
		// entries above 25, encrypt, then shorten mid block
		add_cfg(REG_MODE, 20'd0); add_cfg(REG_KEY_A, 20'hFFFFF);
		add_cfg(REG_KEY_B, 20'hFFFFF);
		add_letter(5'd7); add_letter(5'd19);
		add_cfg(REG_BLEN, 20'd1);
		add_letter(5'd11);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				drain();
				write_reg(dir_rows[k].idx, dir_rows[k].data);
			end else
				send_letter(letter_t'(dir_rows[k].data), dir_rows[k].fixed,
					dir_rows[k].fixed_letter, dir_rows[k].fixed_err);
		end

		sent = 0;
		ph = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			write_reg(REG_MODE, 20'($urandom_range(0, 1)));
			write_reg(REG_BLEN, 20'((ph % 5 == 0) ? $urandom_range(0, 7) :
				$urandom_range(1, 4)));
			for (i = 0; i < 4; i++) begin
				rr = cfg_reg_t'(REG_KEY_A + i);
				case ($urandom_range(0, 5))
					0: write_reg(rr, 20'hFFFFF);
					1: write_reg(rr, 20'h0);
					2: write_reg(rr, 20'(1 << (5 * i)) | 20'($urandom_range(0, 25) << (5 * ((i + 1) % 4))));
					default: write_reg(rr, 20'($urandom()));
				endcase
			end
			if (ph == 2) hold_left = 400;
			cnt = $urandom_range(15, 50);
			if (sent + cnt > RANDOM_ITEMS) cnt = RANDOM_ITEMS - sent;
			for (i = 0; i < cnt; i++) send_letter(letter_t'($urandom_range(0, 25)));
			sent += cnt;
			ph++;
		end

		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0) $display("hill_cipher_block_mod26 test passed");
		else $display("hill_cipher_block_mod26 test failed");
		$finish;
	end

endmodule

// File: files.f
rtl/hcb_pkg.sv
rtl/hcb_cell.sv
rtl/hcb_inv.sv
rtl/hill_cipher_block_mod26.sv
rtl/hcb_checker.sv
tb/hill_cipher_block_mod26_test.sv
